[rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants and types for the scroll camera position update block.
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int COORD_BITS = 32;
    localparam int WIDE_BITS  = COORD_BITS + 4;
    localparam int DVD_BITS   = 40;
    localparam int SIZE_BITS  = 16;
    localparam int CNT_BITS   = $clog2(DVD_BITS);

    localparam logic [23:0] UNLIMITED_STEP = 24'd9999999;
    localparam logic [6:0]  PERCENT        = 7'd100;

    // mode_flags bit positions
    localparam int FLAG_FG_HWRAP   = 0;
    localparam int FLAG_FG_VWRAP   = 1;
    localparam int FLAG_BK_HWRAP   = 2;
    localparam int FLAG_BK_VWRAP   = 3;
    localparam int FLAG_HOLD_ON    = 4;
    localparam int FLAG_PUSH_ON    = 5;
    localparam int FLAG_BK_PRESENT = 6;

    typedef logic signed [WIDE_BITS-1:0] wide_t;
    typedef logic signed [DVD_BITS-1:0]  dvd_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [3:0] {
        REG_VIEW_SIZE  = 4'd0,
        REG_FRONT_SIZE = 4'd1,
        REG_BACK_SIZE  = 4'd2,
        REG_HOLD_ZONE  = 4'd3,
        REG_PUSH_ZONE  = 4'd4,
        REG_STEP_LIMIT = 4'd5,
        REG_PARALLAX   = 4'd6,
        REG_MODE_FLAGS = 4'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_MOVE,
        ST_CLAMP,
        ST_DIV_BX,
        ST_DIV_BY,
        ST_BCLAMP,
        ST_MOD_FX,
        ST_MOD_FY,
        ST_MOD_BX,
        ST_MOD_BY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DVD_BITS-1:0]  dividend;
        logic [SIZE_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DVD_BITS-1:0]  quotient;
        logic [SIZE_BITS-1:0] remainder;
    } div_rsp_t;

endpackage

[rtl/scp_serial_div.sv]
// ----------------------------------------------------------------------------
// scp_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scp_serial_div
    import scp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_BITS-1:0]  dq_reg;
    logic [SIZE_BITS-1:0] rem_reg;
    logic [SIZE_BITS-1:0] dsr_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [SIZE_BITS:0]   rem_shift;
    logic                 ge;
    logic [SIZE_BITS:0]   rem_sub;

    assign rem_shift = {rem_reg, dq_reg[DVD_BITS-1]};
    assign ge        = rem_shift >= {1'b0, dsr_reg};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DVD_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dq_reg  <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DVD_BITS-2:0], ge};
            rem_reg <= ge ? rem_sub[SIZE_BITS-1:0] : rem_shift[SIZE_BITS-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dq_reg;
    assign rsp.remainder = rem_reg;

endmodule

[rtl/scroll_camera_position_update.sv]
// ----------------------------------------------------------------------------
// scroll_camera_position_update
// Per-frame update of a two-layer scrolling viewport following a camera.
// ----------------------------------------------------------------------------
// Requests: s_ready is high only when idle, so a new request waits until the
//   last result has been handed to the output register. The sequencer uses the
//   shared bit-serial divider six times per request (two parallax divides,
//   four offset remainders).
// Reset: aresetn (synchronous, active low) clears the state machine, the
//   stored positions and the configuration registers to their defaults.
module scroll_camera_position_update
    import scp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [63:0]           cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_write_position,
    input  logic signed [31:0]    s_new_pos_x,
    input  logic signed [31:0]    s_new_pos_y,
    input  logic                  s_camera_present,
    input  logic                  s_box_valid,
    input  logic signed [31:0]    s_box_left,
    input  logic signed [31:0]    s_box_top,
    input  logic signed [31:0]    s_box_right,
    input  logic signed [31:0]    s_box_bottom,
    input  logic signed [31:0]    s_camera_x,
    input  logic signed [31:0]    s_camera_y,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_front_pos_x,
    output logic signed [31:0]    m_front_pos_y,
    output logic signed [31:0]    m_back_pos_x,
    output logic signed [31:0]    m_back_pos_y,
    output logic [15:0]           m_front_off_x,
    output logic [15:0]           m_front_off_y,
    output logic [15:0]           m_back_off_x,
    output logic [15:0]           m_back_off_y
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] view_size_reg, front_size_reg, back_size_reg;
    logic [63:0] hold_zone_reg, push_zone_reg;
    logic [15:0] step_limit_reg, parallax_reg;
    logic [6:0]  mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_size_reg  <= 32'd0;
            front_size_reg <= 32'h0001_0001;
            back_size_reg  <= 32'h0001_0001;
            hold_zone_reg  <= 64'd0;
            push_zone_reg  <= 64'd0;
            step_limit_reg <= 16'd0;
            parallax_reg   <= 16'd200;
            mode_reg       <= 7'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VIEW_SIZE:  view_size_reg  <= cfg_data[31:0];
                REG_FRONT_SIZE: front_size_reg <= cfg_data[31:0];
                REG_BACK_SIZE:  back_size_reg  <= cfg_data[31:0];
                REG_HOLD_ZONE:  hold_zone_reg  <= cfg_data;
                REG_PUSH_ZONE:  push_zone_reg  <= cfg_data;
                REG_STEP_LIMIT: step_limit_reg <= cfg_data[15:0];
                REG_PARALLAX:   parallax_reg   <= cfg_data[15:0];
                REG_MODE_FLAGS: mode_reg       <= cfg_data[6:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Field views of the configuration
    logic [15:0] view_w, view_h, fw, fh, bw, bh;
    assign view_w = view_size_reg[31:16];
    assign view_h = view_size_reg[15:0];
    assign fw     = front_size_reg[31:16];
    assign fh     = front_size_reg[15:0];
    assign bw     = back_size_reg[31:16];
    assign bh     = back_size_reg[15:0];

    logic back_on;
    assign back_on = mode_reg[FLAG_BK_PRESENT];

    // Zone edges, signed view coordinates
    logic signed [15:0] hold_l, hold_t, hold_r, hold_b;
    logic signed [15:0] push_l, push_t, push_r, push_b;
    assign hold_l = hold_zone_reg[63:48];
    assign hold_t = hold_zone_reg[47:32];
    assign hold_r = hold_zone_reg[31:16];
    assign hold_b = hold_zone_reg[15:0];
    assign push_l = push_zone_reg[63:48];
    assign push_t = push_zone_reg[47:32];
    assign push_r = push_zone_reg[31:16];
    assign push_b = push_zone_reg[15:0];

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    coord_t front_x_reg, front_y_reg, back_x_reg, back_y_reg;

    // captured request
    logic   cam_reg, boxv_reg;
    coord_t box_l_reg, box_t_reg, box_r_reg, box_b_reg, cam_x_reg, cam_y_reg;

    // working values
    wide_t  fx_reg, fy_reg, speed_reg;
    dvd_t   bx_reg, by_reg;
    logic [15:0] fox_reg, foy_reg, box_reg, boy_reg;
    logic   div_run_reg;

    // output register
    logic   m_valid_reg;
    coord_t out_fx_reg, out_fy_reg, out_bx_reg, out_by_reg;
    logic [15:0] out_fox_reg, out_foy_reg, out_box_reg, out_boy_reg;

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    scp_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    function automatic logic [31:0] mag32(input coord_t v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Turn a magnitude remainder into a nonnegative offset of the sign's value
    function automatic logic [15:0] fix_off(input logic neg, input logic [15:0] rem,
                                            input logic [15:0] size);
        logic [15:0] r;
        r = (neg && rem != 16'd0) ? size - rem : rem;
        return (size == 16'd0) ? 16'd0 : r;
    endfunction

    coord_t fx32, fy32, bx32, by32;
    assign fx32 = fx_reg[31:0];
    assign fy32 = fy_reg[31:0];
    assign bx32 = bx_reg[31:0];
    assign by32 = by_reg[31:0];

    logic div_state;
    always_comb begin
        div_req = '0;
        div_state = 1'b0;
        case (state_reg)
            ST_DIV_BX: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(fx32)) * DVD_BITS'(PERCENT);
                div_req.divisor  = parallax_reg;
            end
            ST_DIV_BY: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(fy32)) * DVD_BITS'(PERCENT);
                div_req.divisor  = parallax_reg;
            end
            ST_MOD_FX: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(fx32));
                div_req.divisor  = fw;
            end
            ST_MOD_FY: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(fy32));
                div_req.divisor  = fh;
            end
            ST_MOD_BX: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(bx32));
                div_req.divisor  = bw;
            end
            ST_MOD_BY: begin
                div_state        = 1'b1;
                div_req.dividend = DVD_BITS'(mag32(by32));
                div_req.divisor  = bh;
            end
            default: ;
        endcase
        div_req.start = div_state && !div_run_reg;
    end

    // ------------------------------------------------------------------
    // Step limit: hold zone stops, push zone overshoot, else configured
    // ------------------------------------------------------------------
    wide_t x0, y0, x1, y1, speed_calc;
    logic  hold_hit;
    always_comb begin
        x0 = wide_t'(box_l_reg) - fx_reg;
        y0 = wide_t'(box_t_reg) - fy_reg;
        x1 = wide_t'(box_r_reg) - fx_reg;
        y1 = wide_t'(box_b_reg) - fy_reg;
        hold_hit = mode_reg[FLAG_HOLD_ON] &&
                   x0 < wide_t'(hold_r) && y0 < wide_t'(hold_b) &&
                   x1 > wide_t'(hold_l) && y1 > wide_t'(hold_t);
        speed_calc = (step_limit_reg != 16'd0) ? wide_t'(step_limit_reg)
                                               : wide_t'(UNLIMITED_STEP);
        if (boxv_reg) begin
            if (hold_hit) begin
                speed_calc = '0;
            end else if (mode_reg[FLAG_PUSH_ON]) begin
                // last firing edge wins: right, below, left, above
                if (x0 > wide_t'(push_r)) speed_calc = x0 - wide_t'(push_r);
                if (y0 > wide_t'(push_b)) speed_calc = y0 - wide_t'(push_b);
                if (x1 < wide_t'(push_l)) speed_calc = wide_t'(push_l) - x1;
                if (y1 < wide_t'(push_t)) speed_calc = wide_t'(push_t) - y1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Move toward the camera centred in the view
    // ------------------------------------------------------------------
    function automatic wide_t approach(input wide_t p, input wide_t c, input wide_t s);
        wide_t up, dn;
        up = p + s;
        dn = p - s;
        if (p < c) return (up < c) ? up : c;
        if (p > c) return (dn > c) ? dn : c;
        return p;
    endfunction

    wide_t cx, cy;
    assign cx = wide_t'(cam_x_reg) - wide_t'({1'b0, view_w[15:1]});
    assign cy = wide_t'(cam_y_reg) - wide_t'({1'b0, view_h[15:1]});

    // Clamp to [0, size - view]; map smaller than view gives zero
    function automatic dvd_t clamp_pos(input dvd_t p, input logic [15:0] size,
                                       input logic [15:0] view);
        dvd_t hi, r;
        hi = dvd_t'($signed({1'b0, size})) - dvd_t'($signed({1'b0, view}));
        r = (p > hi) ? hi : p;
        return (r < 0) ? dvd_t'(0) : r;
    endfunction

    dvd_t fx_cl, fy_cl, bx_cl, by_cl;
    always_comb begin
        fx_cl = mode_reg[FLAG_FG_HWRAP] ? dvd_t'(fx_reg) : clamp_pos(dvd_t'(fx_reg), fw, view_w);
        fy_cl = mode_reg[FLAG_FG_VWRAP] ? dvd_t'(fy_reg) : clamp_pos(dvd_t'(fy_reg), fh, view_h);
        bx_cl = (back_on && !mode_reg[FLAG_BK_HWRAP]) ? clamp_pos(bx_reg, bw, view_w) : bx_reg;
        by_cl = (back_on && !mode_reg[FLAG_BK_VWRAP]) ? clamp_pos(by_reg, bh, view_h) : by_reg;
    end

    // signed quotient, truncating toward zero
    dvd_t q_signed;
    always_comb begin
        if (state_reg == ST_DIV_BX) begin
            q_signed = fx32[31] ? -dvd_t'(div_rsp.quotient) : dvd_t'(div_rsp.quotient);
        end else begin
            q_signed = fy32[31] ? -dvd_t'(div_rsp.quotient) : dvd_t'(div_rsp.quotient);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SPEED;
            ST_SPEED:  state_next = ST_MOVE;
            ST_MOVE:   state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_DIV_BX;
            ST_DIV_BX: if (div_rsp.done) state_next = ST_DIV_BY;
            ST_DIV_BY: if (div_rsp.done) state_next = ST_BCLAMP;
            ST_BCLAMP: state_next = ST_MOD_FX;
            ST_MOD_FX: if (div_rsp.done) state_next = ST_MOD_FY;
            ST_MOD_FY: if (div_rsp.done) state_next = ST_MOD_BX;
            ST_MOD_BX: if (div_rsp.done) state_next = ST_MOD_BY;
            ST_MOD_BY: if (div_rsp.done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and stored positions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_run_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            front_x_reg <= '0;
            front_y_reg <= '0;
            back_x_reg  <= '0;
            back_y_reg  <= '0;
        end else begin
            if (div_req.start) begin
                div_run_reg <= 1'b1;
            end else if (div_state && div_rsp.done) begin
                div_run_reg <= 1'b0;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                front_x_reg <= fx32;
                front_y_reg <= fy32;
                back_x_reg  <= bx32;
                back_y_reg  <= by32;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // software write replaces the position before tracking
                    fx_reg    <= wide_t'(s_write_position ? s_new_pos_x : front_x_reg);
                    fy_reg    <= wide_t'(s_write_position ? s_new_pos_y : front_y_reg);
                    cam_reg   <= s_camera_present;
                    boxv_reg  <= s_box_valid;
                    box_l_reg <= s_box_left;
                    box_t_reg <= s_box_top;
                    box_r_reg <= s_box_right;
                    box_b_reg <= s_box_bottom;
                    cam_x_reg <= s_camera_x;
                    cam_y_reg <= s_camera_y;
                end
            end
            ST_SPEED: speed_reg <= speed_calc;
            ST_MOVE: begin
                if (cam_reg) begin
                    fx_reg <= approach(fx_reg, cx, speed_reg);
                    fy_reg <= approach(fy_reg, cy, speed_reg);
                end
            end
            ST_CLAMP: begin
                // clamp, then wrap to coordinate width
                fx_reg <= wide_t'($signed(fx_cl[COORD_BITS-1:0]));
                fy_reg <= wide_t'($signed(fy_cl[COORD_BITS-1:0]));
            end
            ST_DIV_BX: begin
                if (div_rsp.done) begin
                    bx_reg <= (parallax_reg != 16'd0) ? q_signed : dvd_t'(back_x_reg);
                end
            end
            ST_DIV_BY: begin
                if (div_rsp.done) begin
                    by_reg <= (parallax_reg != 16'd0) ? q_signed : dvd_t'(back_y_reg);
                end
            end
            ST_BCLAMP: begin
                bx_reg <= dvd_t'($signed(bx_cl[COORD_BITS-1:0]));
                by_reg <= dvd_t'($signed(by_cl[COORD_BITS-1:0]));
            end
            ST_MOD_FX: begin
                if (div_rsp.done) fox_reg <= fix_off(fx32[31], div_rsp.remainder, fw);
            end
            ST_MOD_FY: begin
                if (div_rsp.done) foy_reg <= fix_off(fy32[31], div_rsp.remainder, fh);
            end
            ST_MOD_BX: begin
                if (div_rsp.done) begin
                    box_reg <= back_on ? fix_off(bx32[31], div_rsp.remainder, bw) : 16'd0;
                end
            end
            ST_MOD_BY: begin
                if (div_rsp.done) begin
                    boy_reg <= back_on ? fix_off(by32[31], div_rsp.remainder, bh) : 16'd0;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_fx_reg  <= fx32;
                    out_fy_reg  <= fy32;
                    out_bx_reg  <= bx32;
                    out_by_reg  <= by32;
                    out_fox_reg <= fox_reg;
                    out_foy_reg <= foy_reg;
                    out_box_reg <= box_reg;
                    out_boy_reg <= boy_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_front_pos_x = out_fx_reg;
    assign m_front_pos_y = out_fy_reg;
    assign m_back_pos_x  = out_bx_reg;
    assign m_back_pos_y  = out_by_reg;
    assign m_front_off_x = out_fox_reg;
    assign m_front_off_y = out_foy_reg;
    assign m_back_off_x  = out_box_reg;
    assign m_back_off_y  = out_boy_reg;

endmodule
